// ===== rtl/jtl_pkg.sv =====
// Package for the JSON token lexer: token kinds, lexer modes and the result record.
// Used by jtl_step, jtl_out_fifo and json_token_lexer_core; depends on nothing.
package jtl_pkg;

	typedef enum logic [3:0] {
		KIND_LBRACKET = 4'd0,
		KIND_RBRACKET = 4'd1,
		KIND_LBRACE   = 4'd2,
		KIND_RBRACE   = 4'd3,
		KIND_COMMA    = 4'd4,
		KIND_COLON    = 4'd5,
		KIND_STRING   = 4'd6,
		KIND_NUMBER   = 4'd7,
		KIND_TRUE     = 4'd8,
		KIND_FALSE    = 4'd9,
		KIND_NULL     = 4'd10,
		KIND_ERROR    = 4'd11,
		KIND_END      = 4'd12
	} kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE      = 4'd0,
		MODE_STR       = 4'd1,
		MODE_STR_ESC   = 4'd2,
		MODE_NUM_SIGN  = 4'd3,
		MODE_NUM_INT   = 4'd4,
		MODE_NUM_AFTER = 4'd5,
		MODE_NUM_FRAC  = 4'd6,
		MODE_NUM_EXPS  = 4'd7,
		MODE_NUM_EXP   = 4'd8,
		MODE_KW        = 4'd9
	} mode_t;

	// Up to six tokens can come from one byte.
	localparam int MAX_TOK = 6;
	localparam int CNT_BITS = 3;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] start;
		logic [31:0] length;
	} tok_t;

	function automatic logic is_digit(input logic [7:0] b);
		is_digit = (b >= 8'h30) && (b <= 8'h39);
	endfunction

	// Expected byte number m (0-based) after the first letter of keyword k.
	function automatic logic [7:0] kw_rest(input logic [1:0] k, input logic [1:0] m);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			2'd0: begin
				case (m)
					2'd0: r = "r";
					2'd1: r = "u";
					2'd2: r = "e";
					default: r = 8'h00;
				endcase
			end
			2'd1: begin
				case (m)
					2'd0: r = "a";
					2'd1: r = "l";
					2'd2: r = "s";
					default: r = "e";
				endcase
			end
			default: begin
				case (m)
					2'd0: r = "u";
					2'd1: r = "l";
					2'd2: r = "l";
					default: r = 8'h00;
				endcase
			end
		endcase
		kw_rest = r;
	endfunction

endpackage

// ===== rtl/jtl_step.sv =====
// Combinational next-state and token generation for one byte of the lexer.
// Depends on jtl_pkg.
module jtl_step #(
	parameter int OFFSET_BITS = 32
) (
	input  logic [7:0]             data_byte,
	input  logic                   is_last,
	input  logic [3:0]             mode,
	input  logic [OFFSET_BITS-1:0] pos,
	input  logic [OFFSET_BITS-1:0] open_start,
	input  logic [1:0]             kw_kind,
	input  logic [1:0]             kw_matched,
	output logic [3:0]             mode_nxt,
	output logic [OFFSET_BITS-1:0] pos_nxt,
	output logic [OFFSET_BITS-1:0] open_start_nxt,
	output logic [1:0]             kw_kind_nxt,
	output logic [1:0]             kw_matched_nxt,
	output jtl_pkg::tok_t          toks [jtl_pkg::MAX_TOK],
	output logic [jtl_pkg::CNT_BITS-1:0] tok_cnt
);
	import jtl_pkg::*;

	logic [OFFSET_BITS-1:0] pos1;
	logic [1:0]             kw_len;
	logic [3:0]             kw_tok;
	logic                   fresh;

	assign pos1 = pos + 1'b1;

	always_comb begin
		case (kw_kind)
			2'd0: begin kw_len = 2'd3; kw_tok = KIND_TRUE; end
			2'd1: begin kw_len = 2'd0; kw_tok = KIND_FALSE; end
			default: begin kw_len = 2'd3; kw_tok = KIND_NULL; end
		endcase
	end

	always_comb begin
		logic [CNT_BITS-1:0] n;
		logic [3:0] md;
		logic [OFFSET_BITS-1:0] os;
		logic [1:0] kk, km;
		logic [OFFSET_BITS-1:0] ln;
		logic full_match;
		logic kw_ok;
		logic [2:0] lenv;

		for (int i = 0; i < MAX_TOK; i++) toks[i] = '0;
		n = '0;
		md = mode;
		os = open_start;
		kk = kw_kind;
		km = kw_matched;
		fresh = 1'b0;
		ln = pos - open_start;
		// keyword length: false is 4, others 3 (kw_len 0 stands for 4)
		lenv = (kw_len == 2'd0) ? 3'd4 : {1'b0, kw_len};
		kw_ok = ({1'b0, kw_matched} < lenv) && (data_byte == kw_rest(kw_kind, kw_matched));
		full_match = ({1'b0, kw_matched} + 3'd1 == lenv);

		case (mode)
			MODE_STR: begin
				if (data_byte == 8'h22) begin
					toks[n] = '{KIND_STRING, 32'(open_start), 32'(ln)};
					n = n + 1'b1;
					md = MODE_IDLE;
				end else if (data_byte == 8'h5c) begin
					md = MODE_STR_ESC;
				end
			end
			MODE_STR_ESC: begin
				if (data_byte != 8'h5c) md = MODE_STR;
			end
			MODE_NUM_SIGN: begin
				md = (data_byte == 8'h30) ? MODE_NUM_AFTER : MODE_NUM_INT;
			end
			MODE_NUM_INT, MODE_NUM_AFTER: begin
				if (mode == MODE_NUM_INT && is_digit(data_byte)) begin
					md = mode;
				end else if (data_byte == 8'h2e) begin
					md = MODE_NUM_FRAC;
				end else if (data_byte == 8'h65 || data_byte == 8'h45) begin
					md = MODE_NUM_EXPS;
				end else begin
					toks[n] = '{KIND_NUMBER, 32'(open_start), 32'(ln)};
					n = n + 1'b1;
					fresh = 1'b1;
				end
			end
			MODE_NUM_FRAC: begin
				if (is_digit(data_byte)) begin
					md = mode;
				end else if (data_byte == 8'h65 || data_byte == 8'h45) begin
					md = MODE_NUM_EXPS;
				end else begin
					toks[n] = '{KIND_NUMBER, 32'(open_start), 32'(ln)};
					n = n + 1'b1;
					fresh = 1'b1;
				end
			end
			MODE_NUM_EXPS: begin
				if (data_byte == 8'h2b || data_byte == 8'h2d || is_digit(data_byte)) begin
					md = MODE_NUM_EXP;
				end else begin
					toks[n] = '{KIND_NUMBER, 32'(open_start), 32'(ln)};
					n = n + 1'b1;
					fresh = 1'b1;
				end
			end
			MODE_NUM_EXP: begin
				if (!is_digit(data_byte)) begin
					toks[n] = '{KIND_NUMBER, 32'(open_start), 32'(ln)};
					n = n + 1'b1;
					fresh = 1'b1;
				end
			end
			MODE_KW: begin
				if (kw_ok) begin
					if (full_match) begin
						toks[n] = '{kw_tok, 32'(open_start), 32'(lenv)};
						n = n + 1'b1;
						md = MODE_IDLE;
					end else begin
						km = kw_matched + 2'd1;
					end
				end else begin
					// Every held byte becomes a one-byte error token.
					for (int i = 0; i < 4; i++) begin
						if (i <= int'(kw_matched)) begin
							toks[n] = '{KIND_ERROR, 32'(open_start + OFFSET_BITS'(i)), 32'd1};
							n = n + 1'b1;
						end
					end
					fresh = 1'b1;
				end
			end
			default: fresh = 1'b1;
		endcase

		if (fresh) begin
			md = MODE_IDLE;
			case (data_byte)
				8'h20, 8'h09, 8'h0a, 8'h0d: begin end
				8'h5b: begin toks[n] = '{KIND_LBRACKET, 32'(pos), 32'd1}; n = n + 1'b1; end
				8'h5d: begin toks[n] = '{KIND_RBRACKET, 32'(pos), 32'd1}; n = n + 1'b1; end
				8'h7b: begin toks[n] = '{KIND_LBRACE, 32'(pos), 32'd1}; n = n + 1'b1; end
				8'h7d: begin toks[n] = '{KIND_RBRACE, 32'(pos), 32'd1}; n = n + 1'b1; end
				8'h2c: begin toks[n] = '{KIND_COMMA, 32'(pos), 32'd1}; n = n + 1'b1; end
				8'h3a: begin toks[n] = '{KIND_COLON, 32'(pos), 32'd1}; n = n + 1'b1; end
				8'h22: begin md = MODE_STR; os = pos1; end
				8'h2d: begin md = MODE_NUM_SIGN; os = pos; end
				8'h74, 8'h66, 8'h6e: begin
					md = MODE_KW;
					kk = (data_byte == 8'h74) ? 2'd0 : ((data_byte == 8'h66) ? 2'd1 : 2'd2);
					km = 2'd0;
					os = pos;
				end
				default: begin
					if (is_digit(data_byte)) begin
						md = (data_byte == 8'h30) ? MODE_NUM_AFTER : MODE_NUM_INT;
						os = pos;
					end else begin
						toks[n] = '{KIND_ERROR, 32'(pos), 32'd1};
						n = n + 1'b1;
					end
				end
			endcase
		end

		if (is_last) begin
			ln = pos1 - os;
			if (md == MODE_STR || md == MODE_STR_ESC) begin
				toks[n] = '{KIND_STRING, 32'(os), 32'(ln)};
				n = n + 1'b1;
			end else if (md >= MODE_NUM_SIGN && md <= MODE_NUM_EXP) begin
				toks[n] = '{KIND_NUMBER, 32'(os), 32'(ln)};
				n = n + 1'b1;
			end else if (md == MODE_KW) begin
				for (int i = 0; i < 4; i++) begin
					if (i <= int'(km) && int'(n) < MAX_TOK) begin
						toks[n] = '{KIND_ERROR, 32'(os + OFFSET_BITS'(i)), 32'd1};
						n = n + 1'b1;
					end
				end
			end
			if (int'(n) < MAX_TOK) begin
				toks[n] = '{KIND_END, 32'(pos1), 32'd0};
				n = n + 1'b1;
			end
			md = MODE_IDLE;
			os = '0;
			kk = 2'd0;
			km = 2'd0;
			pos_nxt = '0;
		end else begin
			pos_nxt = pos1;
		end

		mode_nxt = md;
		open_start_nxt = os;
		kw_kind_nxt = kk;
		kw_matched_nxt = km;
		tok_cnt = n;
	end

endmodule

// ===== rtl/jtl_out_fifo.sv =====
// Token queue between the lexer step and the output channel.
// Holds up to sixteen token records; depends on jtl_pkg.
module jtl_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  jtl_pkg::tok_t                 wr_toks [jtl_pkg::MAX_TOK],
	input  logic [jtl_pkg::CNT_BITS-1:0]  wr_cnt,
	output logic                          has_room,
	output logic                          rd_valid,
	output jtl_pkg::tok_t                 rd_tok,
	output logic                          rd_last,
	input  logic                          rd_en
);
	import jtl_pkg::*;

	localparam int DEPTH = 16;
	localparam int AW = 4;

	tok_t       mem_q [DEPTH];
	logic       lst_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic [AW:0]   cnt_nxt;

	assign rd_valid = (cnt_q != '0);
	assign rd_tok = mem_q[rp_q];
	assign rd_last = lst_q[rp_q];
	// Room for a full burst after the possible pop this cycle is not assumed.
	assign has_room = (cnt_q <= (AW+1)'(DEPTH - MAX_TOK));

	always_comb begin
		cnt_nxt = cnt_q;
		if (wr_en) cnt_nxt = cnt_nxt + (AW+1)'(wr_cnt);
		if (rd_en && rd_valid) cnt_nxt = cnt_nxt - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < MAX_TOK; i++) begin
				if (i < int'(wr_cnt)) begin
					mem_q[wp_q + AW'(i)] <= wr_toks[i];
					lst_q[wp_q + AW'(i)] <= (i == int'(wr_cnt) - 1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + AW'(wr_cnt);
			if (rd_en && rd_valid) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_nxt;
		end
	end

endmodule

// ===== rtl/json_token_lexer_core.sv =====
// Top level of the JSON token lexer: input register, lexer step and token queue.
// Depends on jtl_pkg, jtl_step and jtl_out_fifo.
//
// Usage: JSON text enters one byte per transfer on the input channel
// (in_valid / in_stall, data_byte, is_last). Each byte yields zero to six
// token records on the output channel (out_valid / out_stall, token_kind,
// token_start, token_length, last_of_run). last_of_run marks the final
// token caused by one byte. A byte with is_last set flushes any open token,
// adds an end token and returns the lexer to offset zero.
// Throughput: one byte per cycle while the token queue has room; the queue
// drains one token per cycle while the receiver does not stall, so bytes
// that make several tokens slow the input to the output rate. A byte is
// registered, then processed and its tokens are written into the queue.
// Reset clears the lexer state, the offset and the queue. When the receiver
// stalls, the queue fills and in_stall rises once fewer than six free slots
// remain; the held token stays stable on the outputs.
module json_token_lexer_core #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [31:0] token_start,
	output logic [31:0] token_length,
	output logic        last_of_run
);
	import jtl_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [3:0]             mode_q, mode_nxt;
	logic [OFFSET_BITS-1:0] pos_q, pos_nxt;
	logic [OFFSET_BITS-1:0] os_q, os_nxt;
	logic [1:0]             kk_q, kk_nxt, km_q, km_nxt;
	tok_t                   toks [MAX_TOK];
	logic [CNT_BITS-1:0]    tok_cnt;
	logic                   room;
	tok_t                   rd_tok;

	// The registered byte is processed only when the queue can take a full burst.
	logic advance;
	assign advance = vld_s1 && room;
	assign in_stall = vld_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	jtl_step #(.OFFSET_BITS(OFFSET_BITS)) u_step (
		.data_byte(byte_s1), .is_last(last_s1), .mode(mode_q), .pos(pos_q),
		.open_start(os_q), .kw_kind(kk_q), .kw_matched(km_q),
		.mode_nxt(mode_nxt), .pos_nxt(pos_nxt), .open_start_nxt(os_nxt),
		.kw_kind_nxt(kk_nxt), .kw_matched_nxt(km_nxt), .toks(toks), .tok_cnt(tok_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			os_q <= '0;
			kk_q <= 2'd0;
			km_q <= 2'd0;
		end else if (advance) begin
			mode_q <= mode_nxt;
			pos_q <= pos_nxt;
			os_q <= os_nxt;
			kk_q <= kk_nxt;
			km_q <= km_nxt;
		end
	end

	jtl_out_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(advance), .wr_toks(toks), .wr_cnt(tok_cnt),
		.has_room(room), .rd_valid(out_valid), .rd_tok(rd_tok), .rd_last(last_of_run),
		.rd_en(!out_stall)
	);

	assign token_kind = rd_tok.kind;
	assign token_start = rd_tok.start;
	assign token_length = rd_tok.length;

endmodule

// ===== bench/json_token_lexer_core_test.sv =====
// Self-checking bench for json_token_lexer_core: drives JSON text bytes and checks token records.
// Depends on jtl_pkg and the lexer RTL; the scoreboard class below holds the token predictor.
module json_token_lexer_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import jtl_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [31:0] start;
		logic [31:0] length;
		logic        last;
	} token_rec_t;

	// The scoreboard carries its own copy of the lexer state and predicts the
	// tokens that each accepted byte produces.
	class token_scoreboard;
		mode_t       mode;
		logic [31:0] offset;
		logic [31:0] open_start;
		logic [1:0]  kw_kind;
		logic [1:0]  kw_matched;
		token_rec_t  pending[$];
		token_rec_t  this_byte[$];
		int          errors;
		int          checked;

		function void clear_state();
			mode = MODE_IDLE;
			offset = '0;
			open_start = '0;
			kw_kind = '0;
			kw_matched = '0;
		endfunction

		function new();
			clear_state();
			errors = 0;
			checked = 0;
		endfunction

		function void add_token(kind_t k, logic [31:0] s, logic [31:0] l);
			token_rec_t t;
			t.kind = k;
			t.start = s;
			t.length = l;
			t.last = 1'b0;
			if (this_byte.size() < MAX_TOK)
				this_byte.push_back(t);
		endfunction

		function bit digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function logic [7:0] kw_char(logic [1:0] k, logic [1:0] m);
			case (k)
				2'd0: return (m == 0) ? "r" : (m == 1) ? "u" : (m == 2) ? "e" : 8'h00;
				2'd1: return (m == 0) ? "a" : (m == 1) ? "l" : (m == 2) ? "s" : "e";
				default: return (m == 0) ? "u" : (m == 1) ? "l" : (m == 2) ? "l" : 8'h00;
			endcase
		endfunction

		function int kw_size(logic [1:0] k);
			return (k == 2'd1) ? 4 : 3;
		endfunction

		function void start_fresh(logic [7:0] b, logic [31:0] pos);
			mode = MODE_IDLE;
			case (b)
				" ", "\t", "\n", 8'h0d: ;
				"[": add_token(KIND_LBRACKET, pos, 1);
				"]": add_token(KIND_RBRACKET, pos, 1);
				"{": add_token(KIND_LBRACE, pos, 1);
				"}": add_token(KIND_RBRACE, pos, 1);
				",": add_token(KIND_COMMA, pos, 1);
				":": add_token(KIND_COLON, pos, 1);
				"\"": begin
					mode = MODE_STR;
					open_start = pos + 1;
				end
				"-": begin
					mode = MODE_NUM_SIGN;
					open_start = pos;
				end
				"t", "f", "n": begin
					mode = MODE_KW;
					kw_kind = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
					kw_matched = 0;
					open_start = pos;
				end
				default: begin
					if (digit(b)) begin
						mode = (b == "0") ? MODE_NUM_AFTER : MODE_NUM_INT;
						open_start = pos;
					end else begin
						add_token(KIND_ERROR, pos, 1);
					end
				end
			endcase
		endfunction

		// A failed keyword turns every held byte into its own error token.
		function void drop_keyword(logic [1:0] held);
			for (int i = 0; i <= held; i++)
				add_token(KIND_ERROR, open_start + i, 1);
			mode = MODE_IDLE;
		endfunction

		function void close_number(logic [7:0] b, logic [31:0] pos);
			add_token(KIND_NUMBER, open_start, pos - open_start);
			start_fresh(b, pos);
		endfunction

		// Notes one accepted byte and queues the tokens it should produce.
		function void note_byte(logic [7:0] b, logic fin);
			logic [31:0] pos;
			pos = offset;
			this_byte.delete();
			case (mode)
				MODE_STR: begin
					if (b == "\"") begin
						add_token(KIND_STRING, open_start, pos - open_start);
						mode = MODE_IDLE;
					end else if (b == "\\") begin
						mode = MODE_STR_ESC;
					end
				end
				MODE_STR_ESC: if (b != "\\") mode = MODE_STR;
				MODE_NUM_SIGN: mode = (b == "0") ? MODE_NUM_AFTER : MODE_NUM_INT;
				MODE_NUM_INT, MODE_NUM_AFTER: begin
					if (!(mode == MODE_NUM_INT && digit(b))) begin
						if (b == ".") mode = MODE_NUM_FRAC;
						else if (b == "e" || b == "E") mode = MODE_NUM_EXPS;
						else close_number(b, pos);
					end
				end
				MODE_NUM_FRAC: begin
					if (!digit(b)) begin
						if (b == "e" || b == "E") mode = MODE_NUM_EXPS;
						else close_number(b, pos);
					end
				end
				MODE_NUM_EXPS: begin
					if (b == "+" || b == "-" || digit(b)) mode = MODE_NUM_EXP;
					else close_number(b, pos);
				end
				MODE_NUM_EXP: if (!digit(b)) close_number(b, pos);
				MODE_KW: begin
					if (kw_matched < kw_size(kw_kind) && b == kw_char(kw_kind, kw_matched)) begin
						if (kw_matched + 1 == kw_size(kw_kind)) begin
							add_token(kind_t'(KIND_TRUE + kw_kind), open_start,
								kw_size(kw_kind));
							mode = MODE_IDLE;
						end else begin
							kw_matched = kw_matched + 1;
						end
					end else begin
						drop_keyword(kw_matched);
						start_fresh(b, pos);
					end
				end
				default: start_fresh(b, pos);
			endcase
			if (fin) begin
				if (mode == MODE_STR || mode == MODE_STR_ESC)
					add_token(KIND_STRING, open_start, pos + 1 - open_start);
				else if (mode >= MODE_NUM_SIGN && mode <= MODE_NUM_EXP)
					add_token(KIND_NUMBER, open_start, pos + 1 - open_start);
				else if (mode == MODE_KW)
					drop_keyword(kw_matched);
				add_token(KIND_END, pos + 1, 0);
				clear_state();
			end else begin
				offset = pos + 1;
			end
			if (this_byte.size() > 0)
				this_byte[this_byte.size() - 1].last = 1'b1;
			foreach (this_byte[i])
				pending.push_back(this_byte[i]);
		endfunction

		// Compares one accepted token with the oldest prediction.
		function void check_token(logic [3:0] k, logic [31:0] s, logic [31:0] l, logic lst);
			token_rec_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected token kind %0d start %0d length %0d",
					$time, k, s, l);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (k !== e.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
				errors++;
			end
			if (s !== e.start) begin
				$display("%0t: start expected %0d actual %0d", $time, e.start, s);
				errors++;
			end
			if (l !== e.length) begin
				$display("%0t: length expected %0d actual %0d", $time, e.length, l);
				errors++;
			end
			if (lst !== e.last) begin
				$display("%0t: last_of_run expected %0b actual %0b", $time, e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  token_kind;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic        last_of_run;

	json_token_lexer_core dut (.*);

	always #10 clk = ~clk;

	token_scoreboard board = new();
	// Percent chances of a sender gap and of a receiver stall in each cycle.
	int gap_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	byte unsigned text[$];

	// The receiver side: stall at random, check every token transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_token(token_kind, token_start, token_length, last_of_run);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Sends one byte; random idle cycles come first, then the transfer is held
	// until the lexer stops stalling. Valid stays high between back-to-back bytes.
	task automatic send_byte(logic [7:0] b, logic fin);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_last <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_byte(b, fin);
		bytes_sent++;
	endtask

	// Sends the queued text, with the final flag on its last byte when asked.
	task automatic send_text(bit close);
		foreach (text[i])
			send_byte(text[i], close && i == text.size() - 1);
		text.delete();
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endtask

	// Builds a random fragment of mostly well-formed JSON.
	task automatic push_random_piece();
		int n;
		case ($urandom_range(11))
			0: push_str("\"a\\\"b\\\\\"");
			1: begin
				text.push_back("\"");
				n = $urandom_range(5);
				repeat (n) text.push_back(8'($urandom_range(32, 126)));
				text.push_back("\"");
			end
			2: push_str($urandom_range(1) ? "-12.5e+3" : "0.25E7");
			3: begin
				if ($urandom_range(1)) text.push_back("-");
				repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(48, 57)));
				if ($urandom_range(1)) push_str(".4");
				if ($urandom_range(1)) push_str("e-1");
			end
			4: push_str("true");
			5: push_str("false");
			6: push_str("null");
			7: push_str($urandom_range(1) ? "tru" : "fa1");
			8: text.push_back(8'($urandom_range(255)));
			9: push_str(" \t\n\r");
			10: begin
				string p;
				p = "[]{},:";
				text.push_back(p[$urandom_range(5)]);
			end
			default: push_str("nul");
		endcase
	endtask

	// Drops valid, waits until every predicted token has come out, then a few more cycles.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts: every punctuation mark, escaped quotes, double
		// backslash, number shapes, all keywords, keyword mismatch, unknown
		// byte and texts that end inside a string, a number and a keyword.
		push_str("[]{},:\"x\\\"\\\\\"-0 1.5e+2 ");
		send_text(0);
		push_str("true false null nulx \x01");
		text.push_back(8'hff);
		push_str("-");
		send_text(1);
		push_str("\"ab");
		send_text(1);
		push_str("fals");
		send_text(1);
		push_str("7e");
		send_text(1);
		drain();

		// Random texts under each idling setting.
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 11 : 51) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 11 : 51) : 0;
			while (bytes_sent < 40 + (ph + 1) * 100) begin
				repeat ($urandom_range(1, 8)) push_random_piece();
				send_text($urandom_range(3) != 0);
			end
			drain();
		end

		$display("Sent %0d bytes and checked %0d tokens over four idling phases.",
			bytes_sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
